FILE: hdl/catd_pkg.sv
// Shared types, constants and thermistor resistance tables for the charger ADC
// telemetry decoder. No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package catd_pkg;

    localparam int TEMP_FRAC_BITS_DEF = 4;
    localparam int TABLE_DEPTH_DEF    = 156;

    localparam int TAB_A_LEN  = 39;
    localparam int TAB_B_LEN  = 156;
    localparam int OHM_W      = 19;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 44;
    localparam int DIV_CNT_W  = 7;
    localparam int R_W        = 24;
    localparam int TEMP_W     = 20;

    localparam logic [2:0] KIND_VBAT = 3'd0;
    localparam logic [2:0] KIND_VSYS = 3'd1;
    localparam logic [2:0] KIND_VBUS = 3'd2;
    localparam logic [2:0] KIND_IBUS = 3'd3;
    localparam logic [2:0] KIND_IBAT = 3'd4;
    localparam logic [2:0] KIND_DIE  = 3'd5;
    localparam logic [2:0] KIND_TS   = 3'd6;

    localparam logic [1:0] REG_THERM_SEL = 2'd0;
    localparam logic [1:0] REG_TS_STEP   = 2'd1;
    localparam logic [1:0] REG_RT1       = 2'd2;
    localparam logic [1:0] REG_RT2       = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_PREP,
        OP_VRES,
        OP_OPEN,
        OP_TSMUL,
        OP_DEN,
        OP_CLAMP_HOT,
        OP_CLAMP_COLD,
        OP_RSTART,
        OP_RLATCH,
        OP_JCLR,
        OP_JINC,
        OP_FSTART,
        OP_FRES,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic is_volt;
        logic is_ts;
        logic open_hit;
        logic p_zero;
        logic den_neg;
        logic den_zero;
        logic div_busy;
        logic r_cold;
        logic r_hot;
        logic seg_hit;
        logic out_free;
    } status_t;

    localparam logic [OHM_W-1:0] TAB_A [TAB_A_LEN] = '{
        19'd332094, 19'd239900, 19'd175200, 19'd129287, 19'd96358, 19'd72500,
        19'd55046, 19'd42157, 19'd32554, 19'd25339, 19'd19872, 19'd15698,
        19'd12488, 19'd10000, 19'd8059, 19'd6535, 19'd5330, 19'd4372,
        19'd3605, 19'd2989, 19'd2490, 19'd2084, 19'd1753, 19'd1481,
        19'd1256, 19'd1070, 19'd915, 19'd786, 19'd677, 19'd585,
        19'd508, 19'd442, 19'd386, 19'd338, 19'd297, 19'd262,
        19'd231, 19'd205, 19'd182
    };

    localparam logic [OHM_W-1:0] TAB_B [TAB_B_LEN] = '{
        19'd193500, 19'd181461, 19'd170268, 19'd159850, 19'd150146, 19'd141100,
        19'd132659, 19'd124779, 19'd117418, 19'd110537, 19'd104101, 19'd98079,
        19'd92440, 19'd87159, 19'd82210, 19'd77571, 19'd73219, 19'd69137,
        19'd65305, 19'd61707, 19'd58328, 19'd55153, 19'd52169, 19'd49363,
        19'd46724, 19'd44241, 19'd41904, 19'd39704, 19'd37633, 19'd35681,
        19'd33800, 19'd32108, 19'd30474, 19'd28932, 19'd27477, 19'd26104,
        19'd24807, 19'd23583, 19'd22426, 19'd21333, 19'd20300, 19'd19322,
        19'd18398, 19'd17523, 19'd16695, 19'd15912, 19'd15169, 19'd14466,
        19'd13799, 19'd13167, 19'd12568, 19'd11999, 19'd11460, 19'd10948,
        19'd10461, 19'd10000, 19'd9561, 19'd9144, 19'd8747, 19'd8370,
        19'd8011, 19'd7670, 19'd7345, 19'd7036, 19'd6741, 19'd6461,
        19'd6193, 19'd5938, 19'd5695, 19'd5464, 19'd5242, 19'd5031,
        19'd4830, 19'd4638, 19'd4454, 19'd4279, 19'd4111, 19'd3951,
        19'd3797, 19'd3651, 19'd3511, 19'd3377, 19'd3248, 19'd3126,
        19'd3008, 19'd2896, 19'd2788, 19'd2684, 19'd2585, 19'd2490,
        19'd2400, 19'd2312, 19'd2229, 19'd2148, 19'd2071, 19'd1997,
        19'd1927, 19'd1858, 19'd1793, 19'd1730, 19'd1670, 19'd1612,
        19'd1556, 19'd1503, 19'd1451, 19'd1402, 19'd1354, 19'd1309,
        19'd1265, 19'd1222, 19'd1181, 19'd1142, 19'd1104, 19'd1068,
        19'd1033, 19'd1000, 19'd967, 19'd936, 19'd906, 19'd877,
        19'd849, 19'd822, 19'd796, 19'd771, 19'd747, 19'd723,
        19'd701, 19'd679, 19'd658, 19'd638, 19'd600, 19'd600,
        19'd582, 19'd564, 19'd548, 19'd531, 19'd516, 19'd500,
        19'd486, 19'd472, 19'd458, 19'd445, 19'd432, 19'd419,
        19'd407, 19'd396, 19'd385, 19'd374, 19'd364, 19'd353,
        19'd344, 19'd334, 19'd325, 19'd316, 19'd308, 19'd300
    };

    // Resistance in ohms of entry idx of the selected table; zero past its end.
    function automatic logic [OHM_W-1:0] tab_ohm(input logic sel, input logic [7:0] idx);
        logic [OHM_W-1:0] v;
        v = '0;
        if (sel)
        begin
            if (idx < 8'(TAB_B_LEN))
                v = TAB_B[idx];
        end
        else
        begin
            if (idx < 8'(TAB_A_LEN))
                v = TAB_A[idx[5:0]];
        end
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [TEMP_W-1:0] x);
        logic signed [15:0] v;
        if (x > 20'sd32767)
            v = 16'sh7FFF;
        else if (x < -20'sd32768)
            v = 16'sh8000;
        else
            v = x[15:0];
        return v;
    endfunction

endpackage

FILE: hdl/catd_div.sv
// Restoring divider, one quotient bit per cycle, for the telemetry decoder.
// Depends on catd_pkg for its widths.
`timescale 1ns / 1ps

module catd_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [catd_pkg::DIV_NUM_W-1:0]  num,
    input  logic [catd_pkg::DIV_DEN_W-1:0]  den,
    output logic                            busy,
    output logic [catd_pkg::DIV_NUM_W-1:0]  quot
);

    logic                             busy_reg;
    logic [catd_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [catd_pkg::DIV_NUM_W-1:0]   q_reg;
    logic [catd_pkg::DIV_DEN_W-1:0]   den_reg;
    logic [catd_pkg::DIV_DEN_W:0]     rem_reg;
    logic [catd_pkg::DIV_DEN_W:0]     rem_sh;
    logic [catd_pkg::DIV_DEN_W:0]     rem_sub;
    logic                             take;

    always_comb
    begin
        rem_sh  = {rem_reg[catd_pkg::DIV_DEN_W-1:0], q_reg[catd_pkg::DIV_NUM_W-1]};
        take    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= catd_pkg::DIV_CNT_W'(catd_pkg::DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == catd_pkg::DIV_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_sub : rem_sh;
            q_reg   <= {q_reg[catd_pkg::DIV_NUM_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

FILE: hdl/catd_datapath.sv
// Datapath of the telemetry decoder: configuration registers, channel scaling,
// thermistor divider arithmetic, table search and output register.
// Depends on catd_pkg and catd_div.
`timescale 1ns / 1ps

module catd_datapath
#(
    parameter int TEMP_FRAC_BITS = catd_pkg::TEMP_FRAC_BITS_DEF,
    parameter int TABLE_DEPTH    = catd_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  catd_pkg::op_t         op,
    input  logic [15:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [23:0]           cfg_wdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [15:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output catd_pkg::status_t     status
);

    localparam int TW      = catd_pkg::TEMP_W;
    localparam int LAST_A  = ((catd_pkg::TAB_A_LEN < TABLE_DEPTH) ?
                              catd_pkg::TAB_A_LEN : TABLE_DEPTH) - 1;
    localparam int LAST_B  = ((catd_pkg::TAB_B_LEN < TABLE_DEPTH) ?
                              catd_pkg::TAB_B_LEN : TABLE_DEPTH) - 1;
    localparam int NUMF_W  = 26 + TEMP_FRAC_BITS;
    localparam int OHM_W_L = catd_pkg::OHM_W;

    // Division by 100 as a multiply by ceil(2^29 / 100); exact for inputs below 2^22.
    localparam logic [22:0] VDIV_MUL   = 23'd5368710;
    localparam int          VDIV_SHIFT = 29;

    // Configuration registers.
    logic         sel_reg;
    logic [23:0]  step_reg;
    logic [15:0]  rt1_reg;
    logic [15:0]  rt2_reg;

    logic [2:0]   kind_reg;
    logic [15:0]  raw_reg;
    logic [21:0]  vnum_reg;
    logic [35:0]  f_reg;
    logic [31:0]  rr_reg;
    logic [55:0]  p_reg;
    logic [40:0]  a_reg;
    logic [39:0]  b_reg;
    logic [62:0]  num_reg;
    logic signed [41:0] den_reg;
    logic [catd_pkg::R_W-1:0] r_reg;
    logic [7:0]   j_reg;
    logic signed [15:0] val_reg;
    logic         open_reg;
    logic         clamp_reg;
    logic         out_valid_reg;
    logic [15:0]  out_data_reg;
    logic [1:0]   out_user_reg;

    logic                               div_start;
    logic [catd_pkg::DIV_NUM_W-1:0]     div_num;
    logic [catd_pkg::DIV_DEN_W-1:0]     div_den;
    logic                               div_busy;
    logic [catd_pkg::DIV_NUM_W-1:0]     div_q;

    logic               is_volt;
    logic [21:0]        vnum;
    logic [44:0]        vq_prod;
    logic signed [15:0] simple_val;
    logic signed [12:0] die_d;
    logic [12:0]        die_mag;
    logic [12:0]        die_half;
    logic [7:0]         last_idx;
    logic [7:0]         j_inc;

    logic [OHM_W_L-1:0] tab_first;
    logic [OHM_W_L-1:0] tab_last;
    logic [OHM_W_L-1:0] tab_j;
    logic [OHM_W_L-1:0] tab_j1;
    logic [22:0]        hi16;
    logic [22:0]        lo16;
    logic [22:0]        first16;
    logic [22:0]        last16;
    logic [22:0]        span;
    logic [22:0]        diff;
    logic [NUMF_W-1:0]  numf;
    logic [NUMF_W+1:0]  fnum;
    logic [40:0]        f25;
    logic [2:0]         tstep;
    logic signed [TW-1:0] t0_s;
    logic signed [TW-1:0] base_s;
    logic signed [TW-1:0] frac_s;
    logic signed [TW-1:0] hot_s;
    logic signed [TW-1:0] cold_s;
    logic signed [TW-1:0] open_s;

    // Temperature in whole degrees at table entry idx.
    function automatic logic signed [TW-1:0] temp_at(input logic signed [TW-1:0] t0,
                                                     input logic [2:0] ts,
                                                     input logic [7:0] idx);
        logic [10:0] prod;
        prod = 11'(ts) * 11'(idx);
        return t0 + $signed({{(TW-11){1'b0}}, prod});
    endfunction

    always_comb
    begin
        is_volt = (kind_reg == catd_pkg::KIND_VBAT) || (kind_reg == catd_pkg::KIND_VSYS) ||
                  (kind_reg == catd_pkg::KIND_VBUS);
        if (kind_reg == catd_pkg::KIND_VBUS)
            vnum = 22'(raw_reg[14:2]) * 22'd397 + 22'd50;
        else
            vnum = 22'(raw_reg[12:1]) * 22'd199 + 22'd50;
        vq_prod = 45'(vnum_reg) * 45'(VDIV_MUL);

        die_d    = $signed({raw_reg[11], raw_reg[11:0]});
        die_mag  = die_d[12] ? 13'(-die_d) : 13'(die_d);
        die_half = (die_mag + 13'd1) >> 1;

        case (kind_reg)
            catd_pkg::KIND_IBUS: simple_val = $signed(raw_reg & 16'hFFFE);
            catd_pkg::KIND_IBAT: simple_val = (raw_reg == 16'h8000) ? 16'sd0 :
                                              $signed(raw_reg & 16'hFFFC);
            catd_pkg::KIND_DIE:  simple_val = die_d[12] ? -$signed({3'b0, die_half}) :
                                              $signed({3'b0, die_half});
            default:             simple_val = 16'sd0;
        endcase

        last_idx = sel_reg ? 8'(LAST_B) : 8'(LAST_A);
        j_inc    = j_reg + 8'd1;
        tstep    = sel_reg ? 3'd1 : 3'd5;
        t0_s     = sel_reg ? -TW'(30) : -TW'(40);

        tab_first = catd_pkg::tab_ohm(sel_reg, 8'd0);
        tab_last  = catd_pkg::tab_ohm(sel_reg, last_idx);
        tab_j     = catd_pkg::tab_ohm(sel_reg, j_reg);
        tab_j1    = catd_pkg::tab_ohm(sel_reg, j_inc);
        first16   = {tab_first, 4'b0};
        last16    = {tab_last, 4'b0};
        hi16      = {tab_j, 4'b0};
        lo16      = {tab_j1, 4'b0};
        span      = hi16 - lo16;
        diff      = hi16 - r_reg[22:0];
        numf      = NUMF_W'(26'(diff) * 26'(tstep)) << TEMP_FRAC_BITS;
        fnum      = {numf, 1'b0} + (NUMF_W+2)'(span);

        f25       = 41'(f_reg) * 41'd25;

        base_s = temp_at(t0_s, tstep, j_reg) <<< TEMP_FRAC_BITS;
        frac_s = (span == '0) ? '0 : $signed({1'b0, div_q[TW-2:0]});
        hot_s  = temp_at(t0_s, tstep, last_idx) <<< TEMP_FRAC_BITS;
        cold_s = t0_s <<< TEMP_FRAC_BITS;
        open_s = -TW'(100) <<< TEMP_FRAC_BITS;

        div_start = 1'b0;
        div_num   = {8'b0, p_reg};
        div_den   = '0;
        case (op)
            catd_pkg::OP_RSTART:
            begin
                div_start = 1'b1;
                div_num   = catd_pkg::DIV_NUM_W'(num_reg);
                div_den   = catd_pkg::DIV_DEN_W'({den_reg[41:0], 1'b0});
            end
            catd_pkg::OP_FSTART:
            begin
                div_start = 1'b1;
                div_num   = catd_pkg::DIV_NUM_W'(fnum);
                div_den   = catd_pkg::DIV_DEN_W'({span, 1'b0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase

        status.is_volt  = is_volt;
        status.is_ts    = kind_reg == catd_pkg::KIND_TS;
        status.open_hit = f25 > (41'd21 << 24);
        status.p_zero   = p_reg == '0;
        status.den_neg  = den_reg < 0;
        status.den_zero = den_reg == '0;
        status.div_busy = div_busy;
        status.r_cold   = r_reg >= catd_pkg::R_W'(first16);
        status.r_hot    = r_reg <= catd_pkg::R_W'(last16);
        status.seg_hit  = ((r_reg <= catd_pkg::R_W'(hi16)) && (r_reg >= catd_pkg::R_W'(lo16))) ||
                          (j_inc == last_idx);
        status.out_free = !out_valid_reg || m_tready;
    end

    catd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= 1'b1;
            step_reg <= 24'd4096;
            rt1_reg  <= 16'd2560;
            rt2_reg  <= 16'd7680;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                catd_pkg::REG_THERM_SEL: sel_reg  <= cfg_wdata[0];
                catd_pkg::REG_TS_STEP:   step_reg <= cfg_wdata;
                catd_pkg::REG_RT1:       rt1_reg  <= cfg_wdata[15:0];
                catd_pkg::REG_RT2:       rt2_reg  <= cfg_wdata[15:0];
                default:                 sel_reg  <= sel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (op == catd_pkg::OP_OUT)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (op)
            catd_pkg::OP_CAPTURE:
            begin
                kind_reg <= s_tuser;
                raw_reg  <= s_tdata;
            end
            catd_pkg::OP_PREP:
            begin
                vnum_reg  <= vnum;
                f_reg     <= 36'(raw_reg[11:0]) * 36'(step_reg);
                rr_reg    <= 32'(rt1_reg) * 32'(rt2_reg);
                val_reg   <= simple_val;
                open_reg  <= 1'b0;
                clamp_reg <= 1'b0;
            end
            catd_pkg::OP_VRES:
                val_reg <= vq_prod[VDIV_SHIFT+15:VDIV_SHIFT];
            catd_pkg::OP_OPEN:
            begin
                val_reg  <= catd_pkg::sat16(open_s);
                open_reg <= 1'b1;
            end
            catd_pkg::OP_TSMUL:
            begin
                p_reg <= 56'(rr_reg) * 56'(f_reg[23:0]);
                a_reg <= 41'(rt2_reg) * 41'(25'h100_0000 - 25'(f_reg[24:0]));
                b_reg <= 40'(rt1_reg) * 40'(f_reg[23:0]);
            end
            catd_pkg::OP_DEN:
            begin
                den_reg <= $signed({1'b0, a_reg}) - $signed({2'b0, b_reg});
                num_reg <= 63'(p_reg) * 63'd125;
            end
            catd_pkg::OP_CLAMP_HOT:
            begin
                val_reg   <= catd_pkg::sat16(hot_s);
                clamp_reg <= 1'b1;
            end
            catd_pkg::OP_CLAMP_COLD:
            begin
                val_reg   <= catd_pkg::sat16(cold_s);
                clamp_reg <= 1'b1;
            end
            catd_pkg::OP_RLATCH:
                r_reg <= (|div_q[catd_pkg::DIV_NUM_W-1:catd_pkg::R_W]) ? '1 :
                         div_q[catd_pkg::R_W-1:0];
            catd_pkg::OP_JCLR:
                j_reg <= 8'd0;
            catd_pkg::OP_JINC:
                j_reg <= j_inc;
            catd_pkg::OP_FRES:
                val_reg <= catd_pkg::sat16(base_s + frac_s);
            catd_pkg::OP_OUT:
            begin
                out_data_reg <= val_reg;
                out_user_reg <= {clamp_reg, open_reg};
            end
            default:
                kind_reg <= kind_reg;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: hdl/catd_ctrl.sv
// Sequencing state machine of the telemetry decoder. Issues one datapath operation
// per cycle from the status it sees, none while it waits. Depends on catd_pkg.
`timescale 1ns / 1ps

module catd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  catd_pkg::status_t  status,
    output catd_pkg::op_t      op
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_PREP   = 11'b000_0000_0010,
        S_VDIV   = 11'b000_0000_0100,
        S_MUL2   = 11'b000_0000_1000,
        S_MUL3   = 11'b000_0001_0000,
        S_CHK    = 11'b000_0010_0000,
        S_RDIV   = 11'b000_0100_0000,
        S_ENDS   = 11'b000_1000_0000,
        S_SEARCH = 11'b001_0000_0000,
        S_FDIV   = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = catd_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op         = catd_pkg::OP_CAPTURE;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                op = catd_pkg::OP_PREP;
                if (status.is_volt)
                    state_next = S_VDIV;
                else if (status.is_ts)
                    state_next = S_MUL2;
                else
                    state_next = S_DONE;
            end
            S_VDIV:
            begin
                op         = catd_pkg::OP_VRES;
                state_next = S_DONE;
            end
            S_MUL2:
            begin
                if (status.open_hit)
                begin
                    op         = catd_pkg::OP_OPEN;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = catd_pkg::OP_TSMUL;
                    state_next = S_MUL3;
                end
            end
            S_MUL3:
            begin
                op         = catd_pkg::OP_DEN;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // Zero or negative resistance reads as the hot end, an open divider as cold.
                if (status.p_zero || status.den_neg)
                begin
                    op         = catd_pkg::OP_CLAMP_HOT;
                    state_next = S_DONE;
                end
                else if (status.den_zero)
                begin
                    op         = catd_pkg::OP_CLAMP_COLD;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = catd_pkg::OP_RSTART;
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (!status.div_busy)
                begin
                    op         = catd_pkg::OP_RLATCH;
                    state_next = S_ENDS;
                end
            end
            S_ENDS:
            begin
                if (status.r_cold)
                begin
                    op         = catd_pkg::OP_CLAMP_COLD;
                    state_next = S_DONE;
                end
                else if (status.r_hot)
                begin
                    op         = catd_pkg::OP_CLAMP_HOT;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = catd_pkg::OP_JCLR;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.seg_hit)
                begin
                    op         = catd_pkg::OP_FSTART;
                    state_next = S_FDIV;
                end
                else
                begin
                    op = catd_pkg::OP_JINC;
                end
            end
            S_FDIV:
            begin
                if (!status.div_busy)
                begin
                    op         = catd_pkg::OP_FRES;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    op         = catd_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/charger_adc_telemetry_decode.sv
// Top level of the charger ADC telemetry decoder: joins the controller and the
// datapath. Depends on catd_pkg, catd_ctrl and catd_datapath.
//
// Usage: a request on the slave channel carries one raw ADC word in s_tdata and
// the channel code in s_tuser. The master channel returns one result per input:
// the engineering value in m_tdata and the sensor-open and clamped flags in
// m_tuser. The user must write the configuration registers through cfg_we /
// cfg_addr / cfg_wdata only while the block is idle; it does not enforce this.
// Path from an accepted request to m_tvalid: current, die and unused channels
// go from capture through preparation to the output register; voltage channels
// add the division by 100, done as a reciprocal multiply. The thermistor channel
// ends early if the sensor is open or is clamped before or after the resistance
// division; else it interpolates: a bit-serial resistance division, a search of
// one table entry per cycle (1 to 155 entries of table B) and a second division.
// One item is decoded at a time; s_tready is high only while idle, so the next
// request can be taken in the cycle after the last result enters the output register.
// A finished result waits there while the next item is decoded; if the receiver
// stalls, the decoder holds its own result until the register is free.
// Reset clears the controller, the output valid and restores register defaults.
`timescale 1ns / 1ps

module charger_adc_telemetry_decode
#(
    parameter int TEMP_FRAC_BITS = catd_pkg::TEMP_FRAC_BITS_DEF,
    parameter int TABLE_DEPTH    = catd_pkg::TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] raw_word
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] value
    output logic [1:0]  m_tuser,   // [0] sensor_open, [1] clamped
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    catd_pkg::op_t     op;
    catd_pkg::status_t status;

    catd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    catd_datapath
    #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS),
        .TABLE_DEPTH    (TABLE_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .status    (status)
    );

endmodule
